// ----- sv/pto_pkg.sv -----
`default_nettype none
package pto_pkg;

	localparam int NODE_W = 7;
	localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		FUNC_NODE   = 2'd0,
		FUNC_CLOSE  = 2'd1,
		FUNC_FINISH = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SEARCH = 5'b00010,
		ST_SWEEP  = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_SCAN   = 5'b10000
	} state_t;

	typedef struct packed {
		logic begin_pass;
		logic sweep_rd;
		logic scan_step;
		logic pick;
		logic pass_done;
		logic pass_ok;
	} ctl_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic scan_hit;
		logic scan_end;
		logic last_pick;
		logic final_pass;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ----- sv/pto_ram.sv -----
`default_nettype none
module pto_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                      wdata,
	input  wire                                   re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/pto_datapath.sv -----
`default_nettype none
module pto_datapath #(
	parameter int MAX_NODES        = 64,
	parameter int MAX_EDGES        = 1024,
	parameter int MAX_OBSERVATIONS = 1024
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           accept,
	input  wire  [1:0]                    func,
	input  wire  [pto_pkg::NODE_W-1:0]    node_id,
	input  wire                           cfg_we,
	input  wire  [pto_pkg::NODE_W-1:0]    cfg_data,
	input  pto_pkg::ctl_cmd_t             cmd,
	output pto_pkg::ctl_sts_t             sts,
	output logic                          result_strobe,
	output logic [pto_pkg::NODE_W-1:0]    order_node,
	output logic                          is_last,
	output logic                          edge_overflow
);
	import pto_pkg::*;

	localparam int NCLIP = (MAX_NODES > 127) ? 127 : MAX_NODES;
	localparam int NIW   = $clog2(NCLIP + 1);
	localparam int AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW    = $clog2(MAX_EDGES + 1);
	localparam int OW    = $clog2(MAX_OBSERVATIONS + 1);
	localparam int TW    = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
	localparam int DW    = 2 * NODE_W + TW;
	localparam logic [NODE_W-1:0] NMAX = NCLIP[NODE_W-1:0];
	localparam logic [EW-1:0] EMAX = EW'(MAX_EDGES);
	localparam logic [OW-1:0] OMAX = OW'(MAX_OBSERVATIONS);

	logic [NODE_W-1:0] node_count_q;
	logic [NODE_W-1:0] n_eff;
	logic [EW-1:0]     edge_total_q;
	logic [OW-1:0]     obs_total_q;
	logic [NODE_W-1:0] prev_q;
	logic              ovf_q;
	logic [OW-1:0]     lo_q, hi_q, k_q;
	logic              final_q;
	logic [EW-1:0]     e_q;
	logic [NODE_W:0]   v_q;
	logic [NODE_W-1:0] picks_q;
	logic [NCLIP:0]    emitted_q, blocked_q;
	logic              rd_valid_s1;

	logic              node_ok, mem_we;
	logic [DW-1:0]     wdata, rdata;
	logic [NODE_W-1:0] rd_from, rd_to;
	logic [TW-1:0]     rd_tag;
	logic              edge_live;
	logic [OW:0]       mid_sum;
	logic [OW-1:0]     mid, hi_init;

	always_comb begin
		if (node_count_q == '0) begin
			n_eff = NODE_W'(1);
		end else if (node_count_q > NMAX) begin
			n_eff = NMAX;
		end else begin
			n_eff = node_count_q;
		end
	end

	assign node_ok = (node_id != '0) && (node_id <= n_eff);
	assign mem_we  = accept && (func == FUNC_NODE) && node_ok && (prev_q != '0)
		&& (edge_total_q < EMAX) && (obs_total_q < OMAX);
	assign wdata   = {prev_q, node_id, obs_total_q[TW-1:0]};

	pto_ram #(.WIDTH(DW), .DEPTH(MAX_EDGES)) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(edge_total_q[AW-1:0]),
		.wdata(wdata),
		.re   (cmd.sweep_rd),
		.raddr(e_q[AW-1:0]),
		.rdata(rdata)
	);

	assign rd_from = rdata[DW-1 -: NODE_W];
	assign rd_to   = rdata[TW +: NODE_W];
	assign rd_tag  = rdata[TW-1:0];

	// A prefix edge blocks its target until its source is placed.
	assign edge_live = (OW'(rd_tag) < k_q) && (rd_from <= n_eff) && (rd_to <= n_eff)
		&& !emitted_q[rd_from[NIW-1:0]];

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (OW + 1)'(1);
	assign mid     = mid_sum[OW:1];
	assign hi_init = (obs_total_q < OMAX) ? (obs_total_q + OW'(1)) : OMAX;

	always_comb begin
		sts.sweep_done = (e_q == edge_total_q);
		sts.scan_end   = (v_q > {1'b0, n_eff});
		sts.scan_hit   = !sts.scan_end && !emitted_q[v_q[NIW-1:0]]
			&& !blocked_q[v_q[NIW-1:0]];
		sts.last_pick  = (picks_q == n_eff - NODE_W'(1));
		sts.final_pass = final_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
			edge_total_q <= '0;
			obs_total_q  <= '0;
			prev_q       <= '0;
			ovf_q        <= 1'b0;
			lo_q         <= '0;
			hi_q         <= '0;
			k_q          <= '0;
			final_q      <= 1'b0;
			e_q          <= '0;
			v_q          <= '0;
			picks_q      <= '0;
			emitted_q    <= '0;
			blocked_q    <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.sweep_rd;
			if (cfg_we) begin
				node_count_q <= cfg_data;
			end
			if (accept) begin
				unique case (func)
					FUNC_NODE: begin
						if (node_ok) begin
							if (prev_q != '0) begin
								if (mem_we) begin
									edge_total_q <= edge_total_q + EW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							prev_q <= node_id;
						end
					end
					FUNC_CLOSE: begin
						prev_q <= '0;
						if (obs_total_q < OMAX) begin
							obs_total_q <= obs_total_q + OW'(1);
						end
					end
					FUNC_FINISH: begin
						lo_q <= '0;
						hi_q <= hi_init;
					end
					default: begin
					end
				endcase
			end
			if (cmd.begin_pass) begin
				if (lo_q < hi_q) begin
					k_q     <= mid;
					final_q <= 1'b0;
				end else begin
					k_q     <= lo_q;
					final_q <= 1'b1;
				end
				emitted_q <= '0;
				blocked_q <= '0;
				picks_q   <= '0;
				e_q       <= '0;
				v_q       <= (NODE_W + 1)'(1);
			end
			if (cmd.sweep_rd) begin
				e_q <= e_q + EW'(1);
			end
			if (rd_valid_s1 && edge_live) begin
				blocked_q[rd_to[NIW-1:0]] <= 1'b1;
			end
			if (cmd.scan_step) begin
				v_q <= v_q + (NODE_W + 1)'(1);
			end
			if (cmd.pick) begin
				emitted_q[v_q[NIW-1:0]] <= 1'b1;
				blocked_q <= '0;
				picks_q   <= picks_q + NODE_W'(1);
				e_q       <= '0;
				v_q       <= (NODE_W + 1)'(1);
			end
			if (cmd.pass_done) begin
				if (final_q) begin
					edge_total_q <= '0;
					obs_total_q  <= '0;
					prev_q       <= '0;
					ovf_q        <= 1'b0;
				end else if (cmd.pass_ok) begin
					lo_q <= k_q;
				end else begin
					hi_q <= k_q - OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.pick && final_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			order_node    <= v_q[NODE_W-1:0];
			is_last       <= sts.last_pick;
			edge_overflow <= ovf_q;
		end
	end

endmodule
`default_nettype wire

// ----- sv/pto_controller.sv -----
`default_nettype none
module pto_controller (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                finish,
	input  pto_pkg::ctl_sts_t  sts,
	output pto_pkg::ctl_cmd_t  cmd,
	output logic               busy
);
	import pto_pkg::*;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (finish) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.begin_pass = 1'b1;
				state_d        = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (sts.sweep_done) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.sweep_rd = 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				priority if (sts.scan_end) begin
					cmd.pass_done = 1'b1;
					state_d       = sts.final_pass ? ST_IDLE : ST_SEARCH;
				end else if (sts.scan_hit) begin
					cmd.pick = 1'b1;
					if (sts.last_pick) begin
						cmd.pass_done = 1'b1;
						cmd.pass_ok   = 1'b1;
						state_d       = sts.final_pass ? ST_IDLE : ST_SEARCH;
					end else begin
						state_d = ST_SWEEP;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/prefix_consistent_topo_order.sv -----
`default_nettype none
// Loads ordering observations and emits the smallest topological order that
// agrees with the longest acyclic prefix of them.
// Input: an item transfers on a clock edge with start high and busy low.
// A node element, an observation close or an unknown code leaves busy low,
// so load items may follow back to back. A finish item raises busy and
// runs a binary search over the observation prefix; each probe is a full
// placement pass. One pass places up to node_count nodes, and each placement
// takes one sweep over the stored edges plus a scan over the nodes. The
// search runs about log2(observations) + 2 passes, the last of which emits
// the order.
// Results: result_strobe marks each order node for exactly one cycle, with
// is_last on the final one; the receiver cannot stall, so no flow control.
// The last result appears in the first cycle with busy low.
// Configuration: node_count is written through cfg_valid/cfg_ready while idle.
// Reset clears the loaded batch, the overflow flag and sets node_count to 64.
// The edge memory itself is not cleared; only entries below the count are read.
module prefix_consistent_topo_order #(
	parameter int MAX_NODES        = 64,
	parameter int MAX_EDGES        = 1024,
	parameter int MAX_OBSERVATIONS = 1024
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire  [1:0]                  func,
	input  wire  [pto_pkg::NODE_W-1:0]  node_id,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [pto_pkg::NODE_W-1:0]  cfg_data,
	output logic                        result_strobe,
	output logic [pto_pkg::NODE_W-1:0]  order_node,
	output logic                        is_last,
	output logic                        edge_overflow
);
	import pto_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;
	logic     accept;

	// The node count must not change while a search is running.
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	pto_controller u_ctl (
		.clk   (clk),
		.arst_n(arst_n),
		.finish(accept && (func == FUNC_FINISH)),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	pto_datapath #(
		.MAX_NODES       (MAX_NODES),
		.MAX_EDGES       (MAX_EDGES),
		.MAX_OBSERVATIONS(MAX_OBSERVATIONS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (func),
		.node_id      (node_id),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_strobe(result_strobe),
		.order_node   (order_node),
		.is_last      (is_last),
		.edge_overflow(edge_overflow)
	);

endmodule
`default_nettype wire

// ----- sv/pto_checker.sv -----
`default_nettype none
module pto_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       start,
	input wire       busy,
	input wire [1:0] func,
	input wire       result_strobe,
	input wire [6:0] order_node,
	input wire       is_last
);
	import pto_pkg::*;

	// A finish transfer always starts a computation.
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_FINISH |=> busy)
		else $error("finish transfer did not raise busy");

	// No result can follow a cycle in which the block was idle.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !result_strobe)
		else $error("result after an idle cycle");

	// The last node ends the burst.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && is_last |=> !result_strobe)
		else $error("result after the last node");

	a_node_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> order_node != 7'd0)
		else $error("node zero emitted");

endmodule

bind prefix_consistent_topo_order pto_checker u_pto_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.result_strobe(result_strobe),
	.order_node   (order_node),
	.is_last      (is_last)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none
module tb_top;
	import pto_pkg::*;

	localparam int NODES_MAX = 64;
	localparam int EDGES_MAX = 1024;
	localparam int OBS_MAX   = 1024;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [NODE_W-1:0] node;
		logic              last;
		logic              ovf;
	} order_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        func = FUNC_NONE;
	logic [NODE_W-1:0] node_id = '0;
	logic              cfg_valid = 1'b0;
	logic [NODE_W-1:0] cfg_data = '0;
	wire               busy;
	wire               cfg_ready;
	wire               result_strobe;
	wire [NODE_W-1:0]  order_node;
	wire               is_last;
	wire               edge_overflow;

	prefix_consistent_topo_order u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .node_id(node_id),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_strobe(result_strobe), .order_node(order_node),
		.is_last(is_last), .edge_overflow(edge_overflow)
	);

	always #10 clk = ~clk;

	// Mirror of the block's loaded batch.
	int     m_from [EDGES_MAX];
	int     m_to   [EDGES_MAX];
	int     m_tag  [EDGES_MAX];
	int     m_edges;
	int     m_obs;
	int     m_prev;
	bit     m_ovf;
	int     m_count;
	order_t order_q [$];

	int  errors = 0;
	int  cycles = 0;
	bit  steady = 1'b0;

	function automatic int active_count();
		int nc;
		nc = m_count;
		if (nc < 1) nc = 1;
		if (nc > NODES_MAX) nc = NODES_MAX;
		return nc;
	endfunction

	// Smallest-first Kahn placement over edges of the first k observations.
	function automatic int place_nodes(int k, int n, bit emit);
		int indeg [NODES_MAX+1];
		bit done  [NODES_MAX+1];
		int i, v, e, pick;
		order_t r;
		for (v = 0; v <= NODES_MAX; v++) begin
			indeg[v] = 0;
			done[v] = 0;
		end
		for (e = 0; e < m_edges; e++)
			if (m_tag[e] < k && m_from[e] <= n && m_to[e] <= n) indeg[m_to[e]]++;
		for (i = 0; i < n; i++) begin
			pick = 0;
			for (v = 1; v <= n; v++)
				if (pick == 0 && !done[v] && indeg[v] == 0) pick = v;
			if (pick == 0) return i;
			done[pick] = 1;
			if (emit) begin
				r.node = pick[NODE_W-1:0];
				r.last = (i + 1 == n);
				r.ovf  = m_ovf;
				order_q.insert(order_q.size(), r);
			end
			for (e = 0; e < m_edges; e++)
				if (m_tag[e] < k && m_from[e] == pick && m_to[e] <= n && indeg[m_to[e]] > 0)
					indeg[m_to[e]]--;
		end
		return n;
	endfunction

	function automatic void clear_batch();
		m_edges = 0;
		m_obs = 0;
		m_prev = 0;
		m_ovf = 0;
	endfunction

	function automatic void predict(logic [1:0] f, logic [NODE_W-1:0] id);
		int n, lo, hi, mid, nd;
		n = active_count();
		nd = int'(id);
		case (f)
			FUNC_NODE: begin
				if (nd != 0 && nd <= n) begin
					if (m_prev != 0) begin
						if (m_edges >= EDGES_MAX || m_obs >= OBS_MAX) begin
							m_ovf = 1;
						end else begin
							m_from[m_edges] = m_prev;
							m_to[m_edges] = nd;
							m_tag[m_edges] = m_obs;
							m_edges++;
						end
					end
					m_prev = nd;
				end
			end
			FUNC_CLOSE: begin
				m_prev = 0;
				if (m_obs < OBS_MAX) m_obs++;
			end
			FUNC_FINISH: begin
				lo = 0;
				hi = m_obs + 1;
				if (hi > OBS_MAX) hi = OBS_MAX;
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					if (place_nodes(mid, n, 0) == n) lo = mid;
					else hi = mid - 1;
				end
				void'(place_nodes(lo, n, 1));
				clear_batch();
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		order_t x;
		cycles <= cycles + 1;
		if (result_strobe) begin
			if (order_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result node=%0d", order_node);
			end else begin
				x = order_q.pop_front();
				if (order_node !== x.node || is_last !== x.last || edge_overflow !== x.ovf) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp node=%0d last=%0b ovf=%0b got node=%0d last=%0b ovf=%0b",
							x.node, x.last, x.ovf, order_node, is_last, edge_overflow);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// One item transfer; the caller is at a rising edge.
	task automatic send(logic [1:0] f, logic [NODE_W-1:0] id);
		start <= 1'b1;
		func <= f;
		node_id <= id;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict(f, id);
		if (!steady && $urandom_range(0, 99) < 20) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (order_q.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(logic [NODE_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		m_count = int'(v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		// Reset count of 64, empty batch, then a chain and a cycle.
		send(FUNC_FINISH, 7'd0);
		send(FUNC_NODE, 7'd64);
		send(FUNC_NODE, 7'd1);
		send(FUNC_CLOSE, 7'd127);
		send(FUNC_NODE, 7'd0);
		send(FUNC_NODE, 7'd65);
		send(FUNC_NONE, 7'd5);
		send(FUNC_CLOSE, 7'd0);
		send(FUNC_NODE, 7'd1);
		send(FUNC_NODE, 7'd64);
		send(FUNC_FINISH, 7'd127);
		write_count(7'd0);
		send(FUNC_NODE, 7'd1);
		send(FUNC_NODE, 7'd1);
		send(FUNC_FINISH, 7'd0);
		write_count(7'd127);
		send(FUNC_NODE, 7'd3);
		send(FUNC_NODE, 7'd2);
		send(FUNC_FINISH, 7'd0);
		// Open observation at finish counts as the next one.
		write_count(7'd4);
		send(FUNC_NODE, 7'd4);
		send(FUNC_NODE, 7'd3);
		send(FUNC_CLOSE, 7'd0);
		send(FUNC_NODE, 7'd3);
		send(FUNC_NODE, 7'd4);
		send(FUNC_FINISH, 7'd0);
	endtask

	task automatic test_count_change();
		write_count(7'd10);
		send(FUNC_NODE, 7'd9);
		send(FUNC_NODE, 7'd2);
		send(FUNC_NODE, 7'd5);
		send(FUNC_CLOSE, 7'd0);
		send(FUNC_NODE, 7'd4);
		send(FUNC_NODE, 7'd1);
		write_count(7'd5);
		send(FUNC_FINISH, 7'd0);
	endtask

	task automatic test_store_full();
		write_count(7'd2);
		for (int i = 0; i < EDGES_MAX + 4; i++) send(FUNC_NODE, (i % 2) ? 7'd1 : 7'd2);
		send(FUNC_FINISH, 7'd0);
	endtask

	task automatic test_obs_saturate();
		write_count(7'd3);
		send(FUNC_NODE, 7'd3);
		send(FUNC_NODE, 7'd1);
		for (int i = 0; i < OBS_MAX + 2; i++) send(FUNC_CLOSE, 7'd0);
		send(FUNC_NODE, 7'd2);
		send(FUNC_NODE, 7'd1);
		send(FUNC_FINISH, 7'd0);
	endtask

	task automatic test_random();
		int sent, n, nobs, r;
		sent = 0;
		while (sent < 420) begin
			if (sent > 150 && sent < 260) steady = 1'b1;
			else steady = 1'b0;
			r = $urandom_range(0, 9);
			if (r == 0) n = 64;
			else if (r < 3) n = $urandom_range(1, 3);
			else n = $urandom_range(4, 16);
			write_count(NODE_W'(n));
			nobs = $urandom_range(0, 6);
			for (int o = 0; o < nobs; o++) begin
				r = $urandom_range(0, 5);
				for (int i = 0; i < r; i++) begin
					if ($urandom_range(0, 9) == 0)
						send(2'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 127)));
					else
						send(FUNC_NODE, NODE_W'($urandom_range(1, n)));
					sent++;
				end
				if ($urandom_range(0, 4) != 0) begin
					send(FUNC_CLOSE, NODE_W'($urandom_range(0, 127)));
					sent++;
				end
			end
			send(FUNC_FINISH, NODE_W'($urandom_range(0, 127)));
			sent++;
			// Hold off until the whole order has come back.
			if ($urandom_range(0, 5) == 0) begin
				start <= 1'b0;
				@(posedge clk);
				while (order_q.size() != 0) @(posedge clk);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		m_count = int'(NODE_COUNT_RESET);
		clear_batch();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_count_change();
		test_store_full();
		test_obs_saturate();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && order_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
